// ===== hdl/dcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types, codes and helpers of the directory coherence controller.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int CPUS = 2;

	localparam logic [5:0] OP_LOAD  = 6'd35;
	localparam logic [5:0] OP_STORE = 6'd43;

	localparam logic [1:0] SRC_OWN     = 2'd0;
	localparam logic [1:0] SRC_SIBLING = 2'd1;
	localparam logic [1:0] SRC_MEMORY  = 2'd2;
	localparam logic [1:0] SRC_DIRTY   = 2'd3;

	localparam logic [1:0] CFG_LOCAL   = 2'd0;
	localparam logic [1:0] CFG_SIBLING = 2'd1;
	localparam logic [1:0] CFG_MEMORY  = 2'd2;
	localparam logic [1:0] CFG_DIRTY   = 2'd3;

	localparam logic [7:0] COST_LOCAL_RST   = 8'd1;
	localparam logic [7:0] COST_SIBLING_RST = 8'd30;
	localparam logic [7:0] COST_MEMORY_RST  = 8'd100;
	localparam logic [7:0] COST_DIRTY_RST   = 8'd135;

	localparam logic [31:0] HOME_BIAS = 32'd5;

	typedef enum logic [1:0] {
		DIR_UNCACHED = 2'd0,
		DIR_SHARED   = 2'd1,
		DIR_DIRTY    = 2'd2
	} dir_st_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE,
		ST_DATA,
		ST_MOD,
		ST_LOOK,
		ST_EVAL,
		ST_VREAD,
		ST_VCHK,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic rf_re;
		logic rf_sel_base;
		logic home_re;
		logic home_sel_g;
		logic row_re;
	} ctrl_t;

	// remainder of v by d, valid while v < d * 256
	function automatic logic [15:0] mod_step(input logic [15:0] v, input logic [15:0] d);
		logic [15:0] r;
		r = v;
		for (int k = 7; k >= 0; k--) begin
			if (r >= (d << k)) begin
				r = r - (d << k);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/dcc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/directory_coherence_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directory_coherence_controller_core
// Directory based MSI coherence controller: register file, per-cpu caches,
// home memory and directory held in RAMs, one instruction at a time.
//
// channel   direction  content
// s_axis    in         node, cpu, op, base_reg, data_reg, offset
// m_axis    out        load_data, served_from, cost, total_cost; status in tuser
// cfg       in         cost register writes, index 0..3
//
// every instruction steps through accept, two register-file reads, address
// reduction one byte a cycle, cache and directory read, victim directory
// read and write-back, then the final write.
// after reset all stores read their reset contents through valid bits, no
// clearing pass; the final write waits while the output register is full.
// ----------------------------------------------------------------------------
module directory_coherence_controller_core
	import dcc_pkg::*;
#(
	parameter int NODES          = 4,
	parameter int CACHE_LINES    = 4,
	parameter int WORDS_PER_NODE = 16,
	parameter int REGISTERS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // node, cpu, op, base_reg, data_reg, offset
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // load_data, served_from, cost, total_cost
	output logic        m_axis_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int ADDR_WORDS = NODES * WORDS_PER_NODE;
	localparam int AW         = $clog2(ADDR_WORDS);
	localparam int NW         = NODES * CPUS;
	localparam int NWW        = $clog2(NW);
	localparam int WAYW       = 1 + AW + 32;
	localparam int ROWW       = NW * WAYW;
	localparam int LW         = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
	localparam int RF_DEPTH   = NODES * CPUS * REGISTERS;
	localparam int RW         = $clog2(RF_DEPTH);
	localparam int RIW        = $clog2(REGISTERS);
	localparam int HW         = 32 + 2 + NODES;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [7:0]      cost_q [4];
	logic [1:0]      n_q;
	logic            c_q;
	logic [5:0]      op_q;
	logic [RIW-1:0]  rb_q, rd_q;
	logic [15:0]     offs_q;
	logic [31:0]     sum_q;
	logic [7:0]      mod_r_q;
	logic [1:0]      mod_cnt_q;
	logic [31:0]     val_q;
	logic [ROWW-1:0] row_q;
	logic [HW-1:0]   home_q;
	logic [31:0]     total_q;

	logic            out_vld_q;
	logic [31:0]     out_load_q;
	logic [1:0]      out_from_q;
	logic [7:0]      out_cost_q;
	logic            out_st_q;

	logic            rf_vld_q   [RF_DEPTH];
	logic            home_vld_q [ADDR_WORDS];
	logic            row_vld_q  [CACHE_LINES];

	logic [RW-1:0]   rf_base_addr, rf_data_addr;
	logic [AW-1:0]   g;
	logic [LW-1:0]   ln;
	logic [31:0]     rf_rdata;
	logic [HW-1:0]   home_rdata;
	logic [ROWW-1:0] row_rdata;
	logic [15:0]     mod_next;

	logic            way_vld [NW];
	logic [AW-1:0]   way_tag [NW];
	logic [31:0]     way_dat [NW];
	logic            way_hit [NW];
	logic            nv [NW];
	logic [31:0]     nd [NW];
	logic [ROWW-1:0] new_row;

	logic [NWW-1:0]  own_w, sib_w;
	logic [AW-1:0]   vic_a;
	logic [HW-1:0]   vic_entry;
	logic            need_evict, evict_do;
	logic            is_load, is_store, legal, commit;

	logic [31:0]     h_dat;
	logic [1:0]      h_st;
	logic [NODES-1:0] h_pres;
	logic [31:0]     w_load;
	logic [1:0]      w_from;
	logic [7:0]      w_cost;
	logic            w_st;
	logic [HW-1:0]   home_new;
	logic            inv_en, keep_en;
	logic [NWW-1:0]  keep_w;

	logic            home_we;
	logic [AW-1:0]   home_waddr, home_raddr;
	logic [HW-1:0]   home_wdata;

	// address and way selection
	assign rf_base_addr = RW'((int'(n_q) * CPUS + int'(c_q)) * REGISTERS + int'(rb_q));
	assign rf_data_addr = RW'((int'(n_q) * CPUS + int'(c_q)) * REGISTERS + int'(rd_q));
	assign g            = mod_r_q[AW-1:0];
	assign ln           = LW'(mod_step(16'(mod_r_q), 16'(CACHE_LINES)));
	assign mod_next     = mod_step({mod_r_q, sum_q[31:24]}, 16'(ADDR_WORDS));
	assign own_w        = NWW'({n_q, c_q});
	assign sib_w        = NWW'({n_q, ~c_q});
	assign is_load      = (op_q == OP_LOAD);
	assign is_store     = (op_q == OP_STORE);
	assign legal        = is_load || is_store;
	assign commit       = (state_q == ST_WRITE) && (!out_vld_q || m_axis_tready);

	always_comb begin
		for (int w = 0; w < NW; w++) begin
			way_vld[w] = row_q[w*WAYW];
			way_tag[w] = row_q[w*WAYW+1 +: AW];
			way_dat[w] = row_q[w*WAYW+1+AW +: 32];
			way_hit[w] = way_vld[w] && (way_tag[w] == g);
		end
	end

	assign vic_a      = way_tag[own_w];
	assign need_evict = is_load && way_vld[own_w] && !way_hit[own_w];
	assign vic_entry  = home_vld_q[vic_a] ? home_rdata
	                  : {NODES'(0), DIR_UNCACHED, 32'(vic_a) + HOME_BIAS};
	assign evict_do   = (state_q == ST_VCHK) && need_evict && (vic_entry[33:32] == DIR_DIRTY);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_BASE;
			ST_BASE:  state_d = ST_DATA;
			ST_DATA:  state_d = ST_MOD;
			ST_MOD:   if (mod_cnt_q == 2'd3) state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_VREAD;
			ST_VREAD: state_d = ST_VCHK;
			ST_VCHK:  state_d = ST_WRITE;
			ST_WRITE: if (commit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_BASE:  begin
				ctrl.rf_re       = 1'b1;
				ctrl.rf_sel_base = 1'b1;
			end
			ST_DATA:  ctrl.rf_re = 1'b1;
			ST_LOOK:  begin
				ctrl.home_re    = 1'b1;
				ctrl.home_sel_g = 1'b1;
				ctrl.row_re     = 1'b1;
			end
			ST_VREAD: ctrl.home_re = 1'b1;
			default:  ctrl = '0;
		endcase
	end

	assign s_axis_tready = ctrl.in_ready;
	assign cfg_ready     = 1'b1;

	// final write: result and new contents
	always_comb begin
		h_dat   = home_q[31:0];
		h_st    = home_q[33:32];
		h_pres  = home_q[HW-1:34];
		w_load  = '0;
		w_from  = SRC_OWN;
		w_cost  = '0;
		w_st    = 1'b0;
		inv_en  = 1'b0;
		keep_en = 1'b0;
		keep_w  = own_w;
		for (int w = 0; w < NW; w++) begin
			nv[w] = way_vld[w];
			nd[w] = way_dat[w];
		end
		case (op_q)
			OP_LOAD: begin
				if (way_hit[own_w]) begin
					w_load = way_dat[own_w];
					w_from = SRC_OWN;
					w_cost = cost_q[CFG_LOCAL];
				end else if (way_hit[sib_w]) begin
					w_load = way_dat[sib_w];
					w_from = SRC_SIBLING;
					w_cost = cost_q[CFG_SIBLING];
				end else if (h_st != DIR_DIRTY) begin
					w_load = h_dat;
					w_from = SRC_MEMORY;
					w_cost = cost_q[CFG_MEMORY];
					h_st   = DIR_SHARED;
					h_pres = h_pres | (NODES'(1) << n_q);
				end else begin
					w_load = h_dat;
					for (int w = 0; w < NW; w++) begin
						if (h_pres[w / CPUS] && way_hit[w]) begin
							w_load = way_dat[w];
						end
					end
					w_from = SRC_DIRTY;
					w_cost = cost_q[CFG_DIRTY];
					h_dat  = w_load;
					h_st   = DIR_SHARED;
					h_pres = h_pres | (NODES'(1) << n_q);
				end
				nv[own_w] = 1'b1;
				nd[own_w] = w_load;
			end
			OP_STORE: begin
				if (way_hit[own_w]) begin
					nd[own_w] = val_q;
					inv_en    = 1'b1;
					keep_en   = 1'b1;
					h_st      = DIR_DIRTY;
					w_from    = SRC_OWN;
					w_cost    = cost_q[CFG_LOCAL];
				end else if (way_hit[sib_w]) begin
					nd[sib_w] = val_q;
					inv_en    = 1'b1;
					keep_en   = 1'b1;
					keep_w    = sib_w;
					h_st      = DIR_DIRTY;
					w_from    = SRC_SIBLING;
					w_cost    = cost_q[CFG_LOCAL];
				end else begin
					h_dat  = val_q;
					inv_en = h_pres[n_q];
					w_from = SRC_MEMORY;
					w_cost = cost_q[CFG_MEMORY];
				end
			end
			default: w_st = 1'b1;
		endcase
		for (int w = 0; w < NW; w++) begin
			if (inv_en && (way_tag[w] == g) && !(keep_en && (NWW'(w) == keep_w))) begin
				nv[w] = 1'b0;
			end
		end
		for (int w = 0; w < NW; w++) begin
			new_row[w*WAYW +: WAYW] = {nd[w], (is_load && NWW'(w) == own_w) ? g : way_tag[w],
			                           nv[w]};
		end
		home_new = {h_pres, h_st, h_dat};
	end

	assign home_we    = evict_do || (commit && legal);
	assign home_waddr = (state_q == ST_VCHK) ? vic_a : g;
	assign home_wdata = (state_q == ST_VCHK) ? {vic_entry[HW-1:32], way_dat[own_w]} : home_new;
	assign home_raddr = ctrl.home_sel_g ? g : vic_a;

	dcc_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
		.clk   (clk),
		.we    (commit && is_load),
		.waddr (rf_data_addr),
		.wdata (w_load),
		.re    (ctrl.rf_re),
		.raddr (ctrl.rf_sel_base ? rf_base_addr : rf_data_addr),
		.rdata (rf_rdata)
	);

	dcc_ram #(.WIDTH(HW), .DEPTH(ADDR_WORDS)) u_home (
		.clk   (clk),
		.we    (home_we),
		.waddr (home_waddr),
		.wdata (home_wdata),
		.re    (ctrl.home_re),
		.raddr (home_raddr),
		.rdata (home_rdata)
	);

	dcc_ram #(.WIDTH(ROWW), .DEPTH(CACHE_LINES)) u_cache (
		.clk   (clk),
		.we    (commit && legal),
		.waddr (ln),
		.wdata (new_row),
		.re    (ctrl.row_re),
		.raddr (ln),
		.rdata (row_rdata)
	);

	// control state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mod_cnt_q <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
			cost_q[CFG_LOCAL]   <= COST_LOCAL_RST;
			cost_q[CFG_SIBLING] <= COST_SIBLING_RST;
			cost_q[CFG_MEMORY]  <= COST_MEMORY_RST;
			cost_q[CFG_DIRTY]   <= COST_DIRTY_RST;
			for (int i = 0; i < RF_DEPTH; i++) rf_vld_q[i] <= 1'b0;
			for (int i = 0; i < ADDR_WORDS; i++) home_vld_q[i] <= 1'b0;
			for (int i = 0; i < CACHE_LINES; i++) row_vld_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				cost_q[cfg_index] <= cfg_data;
			end
			if (state_q == ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + 2'd1;
			end
			if (!commit && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (home_we) begin
				home_vld_q[home_waddr] <= 1'b1;
			end
			if (commit) begin
				out_vld_q <= 1'b1;
				total_q   <= total_q + 32'(w_cost);
				if (legal) begin
					row_vld_q[ln] <= 1'b1;
				end
				if (is_load) begin
					rf_vld_q[rf_data_addr] <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			n_q    <= 2'(mod_step(16'(s_axis_tdata[1:0]), 16'(NODES)));
			c_q    <= s_axis_tdata[2];
			op_q   <= s_axis_tdata[8:3];
			rb_q   <= RIW'(mod_step(16'(s_axis_tdata[12:9]), 16'(REGISTERS)));
			rd_q   <= RIW'(mod_step(16'(s_axis_tdata[16:13]), 16'(REGISTERS)));
			offs_q <= s_axis_tdata[32:17];
		end
		if (state_q == ST_DATA) begin
			sum_q   <= 32'(offs_q) + (rf_vld_q[rf_base_addr] ? rf_rdata : 32'd0);
			mod_r_q <= '0;
		end
		if (state_q == ST_MOD) begin
			mod_r_q <= 8'(mod_next);
			sum_q   <= sum_q << 8;
			if (mod_cnt_q == 2'd0) begin
				val_q <= rf_vld_q[rf_data_addr] ? rf_rdata : 32'd0;
			end
		end
		if (state_q == ST_EVAL) begin
			row_q  <= row_vld_q[ln] ? row_rdata : '0;
			home_q <= home_vld_q[g] ? home_rdata
			        : {NODES'(0), DIR_UNCACHED, 32'(g) + HOME_BIAS};
		end
		if (commit) begin
			out_load_q <= w_load;
			out_from_q <= w_from;
			out_cost_q <= w_cost;
			out_st_q   <= w_st;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, total_q, out_cost_q, out_from_q, out_load_q};
	assign m_axis_tuser  = out_st_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_axis_tvalid)
		else $error("result not presented after final write");

	a_total_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(total_q))
		else $error("running total moved without a result");

	a_illegal_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (out_cost_q == 8'd0 && out_load_q == 32'd0))
		else $error("illegal opcode charged or returned data");

	a_mod_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MOD) |-> (mod_cnt_q == 2'd0))
		else $error("address reduction counter out of step");

endmodule
